>>> sv/spin_chain_hamiltonian_row_generator_top_defines.svh
// ----------------------------------------------------------------------------
// j1-j2 ring row generator: assertion macros
// shared concurrent assertion forms, clocked on i_clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SPIN_CHAIN_HAMILTONIAN_ROW_GENERATOR_TOP_DEFINES_SVH
`define SPIN_CHAIN_HAMILTONIAN_ROW_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define SCHRG_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("schrg assertion failed");

// next-cycle implication
`define SCHRG_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("schrg assertion failed");

`endif

>>> sv/schrg_pkg.sv
// ----------------------------------------------------------------------------
// schrg_pkg
// types and constants of the j1-j2 ring row generator
// ----------------------------------------------------------------------------
package schrg_pkg;

    localparam int STATE_W    = 16;  // basis state and column width
    localparam int VAL_W      = 24;  // entry value width
    localparam int CFG_W      = 16;  // coupling ratio width
    localparam int HALF_W     = 4;   // half ring length register width
    localparam int LEN_W      = 5;   // ring length, up to 16
    localparam int CNT_W      = 5;   // bond count, up to 16
    localparam int D_W        = 7;   // signed bond sum
    localparam int T_W        = CFG_W + D_W;  // diagonal sum, 14 fraction bits
    localparam int DIAG_FRAC  = 14;
    localparam int OFF_FRAC   = 13;
    localparam int QUARTER_SH = 12;  // 0.25 with 14 fraction bits
    localparam int HALF_MIN   = 3;
    localparam int HALF_MAX   = 8;
    localparam int QDEPTH     = 4;
    localparam int QLVL_W     = 3;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic REG_COUPLING = 1'b0;
    localparam logic REG_HALF     = 1'b1;

    typedef logic signed [VAL_W-1:0] t_val;
    typedef logic signed [T_W-1:0]   t_acc;

    localparam t_val VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam t_val VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic signed [CFG_W-1:0] COUPLING_RST = 16'sd4096;
    localparam logic [HALF_W-1:0]       HALF_RST     = 4'd8;

    typedef struct packed {
        logic signed [CFG_W-1:0] coupling;
        logic [LEN_W-1:0]        ring_len;
    } t_cfg;

endpackage

>>> sv/schrg_front.sv
// ----------------------------------------------------------------------------
// schrg_front
// two-stage intake: finds antiparallel bonds and sums the diagonal entry
// ----------------------------------------------------------------------------
module schrg_front #(
    parameter int MASK_W = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  schrg_pkg::t_cfg                    i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [schrg_pkg::STATE_W-1:0]      i_basis_state,
    output logic                               o_push,
    input  logic                               i_full,
    output logic [MASK_W-1:0]                  o_state,
    output logic [MASK_W-1:0]                  o_anti1,
    output logic [MASK_W-1:0]                  o_anti2,
    output schrg_pkg::t_acc                    o_diag
);
    import schrg_pkg::*;

    logic [MASK_W:0]   mask_w;
    logic [MASK_W-1:0] ring_mask;
    logic [MASK_W-1:0] s_in;
    logic [MASK_W-1:0] rot1;
    logic [MASK_W-1:0] rot2;
    logic [MASK_W-1:0] a1;
    logic [MASK_W-1:0] a2;
    logic              s2_rdy;

    logic              r_s1_vld;
    logic [MASK_W-1:0] r_s1_state;
    logic [MASK_W-1:0] r_s1_anti1;
    logic [MASK_W-1:0] r_s1_anti2;
    logic [CNT_W-1:0]  r_s1_cnt1;
    logic [CNT_W-1:0]  r_s1_cnt2;

    logic signed [D_W-1:0] d1;
    logic signed [D_W-1:0] d2;
    t_acc                  prod;
    t_acc                  n_acc;

    logic              r_s2_vld;
    logic [MASK_W-1:0] r_s2_state;
    logic [MASK_W-1:0] r_s2_anti1;
    logic [MASK_W-1:0] r_s2_anti2;
    t_acc              r_s2_acc;

    // stage 1: ring mask, neighbor rotations, antiparallel bonds
    always_comb begin
        mask_w    = ((MASK_W+1)'(1) << i_cfg.ring_len) - (MASK_W+1)'(1);
        ring_mask = mask_w[MASK_W-1:0];
        s_in      = i_basis_state[MASK_W-1:0] & ring_mask;
        rot1      = (s_in >> 1)
                  | (MASK_W'(s_in[0]) << (i_cfg.ring_len - LEN_W'(1)));
        rot2      = (s_in >> 2)
                  | (MASK_W'(s_in[0]) << (i_cfg.ring_len - LEN_W'(2)))
                  | (MASK_W'(s_in[1]) << (i_cfg.ring_len - LEN_W'(1)));
        a1        = (s_in ^ rot1) & ring_mask;
        a2        = (s_in ^ rot2) & ring_mask;
    end

    // stage 2: bond sums, then d1/4 + j*d2/4 with 14 fraction bits
    always_comb begin
        d1    = $signed({2'b00, i_cfg.ring_len}) - $signed({1'b0, r_s1_cnt1, 1'b0});
        d2    = $signed({2'b00, i_cfg.ring_len}) - $signed({1'b0, r_s1_cnt2, 1'b0});
        prod  = i_cfg.coupling * d2;
        n_acc = (T_W'(d1) <<< QUARTER_SH) + prod;
    end

    assign s2_rdy  = !r_s2_vld || !i_full;
    assign o_ready = !r_s1_vld || s2_rdy;
    assign o_push  = r_s2_vld && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_vld <= i_valid;
            end
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_state <= s_in;
            r_s1_anti1 <= a1;
            r_s1_anti2 <= a2;
            r_s1_cnt1  <= CNT_W'($countones(a1));
            r_s1_cnt2  <= CNT_W'($countones(a2));
        end
        if (s2_rdy && r_s1_vld) begin
            r_s2_state <= r_s1_state;
            r_s2_anti1 <= r_s1_anti1;
            r_s2_anti2 <= r_s1_anti2;
            r_s2_acc   <= n_acc;
        end
    end

    assign o_state = r_s2_state;
    assign o_anti1 = r_s2_anti1;
    assign o_anti2 = r_s2_anti2;
    assign o_diag  = r_s2_acc;

endmodule

>>> sv/schrg_fifo.sv
// ----------------------------------------------------------------------------
// schrg_fifo
// short queue of classified states between intake and emitter
// ----------------------------------------------------------------------------
module schrg_fifo #(
    parameter int DATA_W = 71,
    parameter int DEPTH  = 4,
    parameter int LVL_W  = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_vld,
    output logic [DATA_W-1:0] o_data,
    output logic [LVL_W-1:0]  o_level
);
    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [LVL_W-1:0]  r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LVL_W'(1);
            end else if (i_pop && !i_push) begin
                r_level <= r_level - LVL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_vld   = (r_level != '0);
    assign o_data  = r_mem[r_rd];
    assign o_level = r_level;

endmodule

>>> sv/schrg_back.sv
// ----------------------------------------------------------------------------
// schrg_back
// row emitter: diagonal entry, then one entry per antiparallel bond
// ----------------------------------------------------------------------------
module schrg_back #(
    parameter int MASK_W    = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  schrg_pkg::t_cfg                      i_cfg,
    input  logic                                 i_vld,
    input  logic [MASK_W-1:0]                    i_state,
    input  logic [MASK_W-1:0]                    i_anti1,
    input  logic [MASK_W-1:0]                    i_anti2,
    input  schrg_pkg::t_acc                      i_diag,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [schrg_pkg::STATE_W-1:0]        o_column_state,
    output logic signed [schrg_pkg::VAL_W-1:0]   o_entry_value,
    output logic                                 o_is_diagonal,
    output logic                                 o_last_of_row
);
    import schrg_pkg::*;

    // diagonal: 14 fraction bits in, FRAC_BITS out
    localparam int UP14  = (FRAC_BITS > DIAG_FRAC) ? FRAC_BITS - DIAG_FRAC : 0;
    localparam int DN14  = (FRAC_BITS < DIAG_FRAC) ? DIAG_FRAC - FRAC_BITS : 0;
    localparam int RND14 = (DN14 > 0) ? (1 << (DN14 - 1)) : 0;
    localparam int W14   = VAL_W + 1 + UP14;
    // next-nearest hop: j times one half, 13 fraction bits in
    localparam int UP13  = (FRAC_BITS > OFF_FRAC) ? FRAC_BITS - OFF_FRAC : 0;
    localparam int DN13  = (FRAC_BITS < OFF_FRAC) ? OFF_FRAC - FRAC_BITS : 0;
    localparam int RND13 = (DN13 > 0) ? (1 << (DN13 - 1)) : 0;
    localparam int W13   = VAL_W + 1 + UP13;
    localparam t_val HALF_VAL = t_val'(1) << (FRAC_BITS - 1);

    function automatic logic [MASK_W-1:0] ring_rotl(
        input logic [MASK_W-1:0] x,
        input logic [1:0]        d,
        input logic [LEN_W-1:0]  n,
        input logic [MASK_W-1:0] m
    );
        logic [MASK_W+1:0] y;
        logic [MASK_W+1:0] hi;
        begin
            y  = {2'b00, x} << d;
            hi = (y & ~{2'b00, m}) >> n;
            return (y[MASK_W-1:0] & m) | hi[MASK_W-1:0];
        end
    endfunction

    logic                  r_act;
    logic                  r_diag_pnd;
    logic [MASK_W-1:0]     r_s;
    logic [2*MASK_W-1:0]   r_pend;
    t_acc                  r_acc;

    logic                  r_out_vld;
    logic [STATE_W-1:0]    r_col;
    t_val                  r_val;
    logic                  r_is_diag;
    logic                  r_last;

    logic [MASK_W:0]       mask_w;
    logic [MASK_W-1:0]     ring_mask;
    logic [2*MASK_W-1:0]   low;
    logic [2*MASK_W-1:0]   pend_nx;
    logic [MASK_W-1:0]     lo1;
    logic [MASK_W-1:0]     lo2;
    logic [MASK_W-1:0]     flip;
    logic                  last;
    logic                  emit;
    logic signed [W14-1:0] x14;
    logic signed [W14-1:0] y14;
    logic signed [W13-1:0] x13;
    logic signed [W13-1:0] y13;
    t_val                  diag_val;
    t_val                  jhalf_val;
    t_val                  n_val;
    logic [MASK_W-1:0]     n_col;

    always_comb begin
        mask_w    = ((MASK_W+1)'(1) << i_cfg.ring_len) - (MASK_W+1)'(1);
        ring_mask = mask_w[MASK_W-1:0];
        low       = r_pend & (~r_pend + (2*MASK_W)'(1));
        pend_nx   = r_pend & ~low;
        lo1       = low[MASK_W-1:0];
        lo2       = low[2*MASK_W-1:MASK_W];
        flip      = lo1 | ring_rotl(lo1, 2'd1, i_cfg.ring_len, ring_mask)
                  | lo2 | ring_rotl(lo2, 2'd2, i_cfg.ring_len, ring_mask);
        last      = r_diag_pnd ? (r_pend == '0) : (pend_nx == '0);
    end

    // round half up, then saturate
    always_comb begin
        x14 = W14'(r_acc) + W14'(RND14);
        y14 = (x14 >>> DN14) <<< UP14;
        if (y14 > W14'(VAL_MAX)) begin
            diag_val = VAL_MAX;
        end else if (y14 < W14'(VAL_MIN)) begin
            diag_val = VAL_MIN;
        end else begin
            diag_val = VAL_W'(y14);
        end
        x13 = W13'(i_cfg.coupling) + W13'(RND13);
        y13 = (x13 >>> DN13) <<< UP13;
        if (y13 > W13'(VAL_MAX)) begin
            jhalf_val = VAL_MAX;
        end else if (y13 < W13'(VAL_MIN)) begin
            jhalf_val = VAL_MIN;
        end else begin
            jhalf_val = VAL_W'(y13);
        end
    end

    always_comb begin
        if (r_diag_pnd) begin
            n_val = diag_val;
            n_col = r_s;
        end else begin
            n_val = (|lo1) ? HALF_VAL : jhalf_val;
            n_col = r_s ^ flip;
        end
    end

    assign emit  = r_act && (!r_out_vld || i_ready);
    assign o_pop = i_vld && (!r_act || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act      <= 1'b0;
            r_diag_pnd <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_act      <= 1'b1;
                r_diag_pnd <= 1'b1;
            end else if (emit && last) begin
                r_act <= 1'b0;
            end else if (emit) begin
                r_diag_pnd <= 1'b0;
            end
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s    <= i_state;
            r_pend <= {i_anti2, i_anti1};
            r_acc  <= i_diag;
        end else if (emit && !r_diag_pnd) begin
            r_pend <= pend_nx;
        end
        if (emit) begin
            r_col     <= STATE_W'(n_col);
            r_val     <= n_val;
            r_is_diag <= r_diag_pnd;
            r_last    <= last;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_column_state = r_col;
    assign o_entry_value  = r_val;
    assign o_is_diagonal  = r_is_diag;
    assign o_last_of_row  = r_last;

endmodule

>>> sv/spin_chain_hamiltonian_row_generator_top.sv
// ----------------------------------------------------------------------------
// spin_chain_hamiltonian_row_generator_top
// Takes one basis state of a periodic spin-1/2 ring (bit i = site i, 1 = up,
// ring length 2*half_sites, at most 16) and emits that state's row of the
// J1-J2 Heisenberg Hamiltonian: first the diagonal entry, then one entry per
// antiparallel bond with both bond spins flipped, nearest bonds in site order
// before next-nearest bonds. Values are signed fixed point with FRAC_BITS
// fraction bits, rounded half up and saturated to 24 bits. A state with b
// antiparallel bonds yields 1 + b results (1 to 25 on a 16-site ring, since
// any three neighboring sites hold at most two antiparallel bonds). The
// emitter puts out one result per clock while the output is ready, so
// sustained throughput is one result per cycle, and a new state is taken
// every cycle while the 4-entry queue ahead of the emitter has room. Each
// request passes the front stages and the queue before the emitter
// registers its first result. Write coupling_ratio (address 0) and
// half_sites (address 4) only while no row is outstanding.
// ----------------------------------------------------------------------------
`include "spin_chain_hamiltonian_row_generator_top_defines.svh"

module spin_chain_hamiltonian_row_generator_top #(
    parameter int MAX_SITES = 16,
    parameter int FRAC_BITS = 12
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // state request channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [schrg_pkg::STATE_W-1:0]        i_basis_state,
    // matrix entry channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [schrg_pkg::STATE_W-1:0]        o_column_state,
    output logic signed [schrg_pkg::VAL_W-1:0]   o_entry_value,
    output logic                                 o_is_diagonal,
    output logic                                 o_last_of_row,
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [schrg_pkg::APB_AW-1:0]         paddr,
    input  logic [schrg_pkg::APB_DW-1:0]         pwdata,
    output logic [schrg_pkg::APB_DW-1:0]         prdata,
    output logic                                 pready
);
    import schrg_pkg::*;

    // site mask width and the longest even ring the build supports
    localparam int MASK_W   = (MAX_SITES < STATE_W) ? MAX_SITES : STATE_W;
    localparam int RING_MAX = (MAX_SITES < STATE_W) ? (MAX_SITES & ~1) : STATE_W;
    localparam int DATA_W   = 3 * MASK_W + T_W;

    // configuration registers
    logic signed [CFG_W-1:0] r_coupling;
    logic [HALF_W-1:0]       r_half;
    logic                    cfg_wr;
    logic [HALF_W-1:0]       half_cl;
    logic [LEN_W-1:0]        len_raw;
    t_cfg                    cfg;

    // front to queue to back
    logic                    q_push;
    logic                    q_pop;
    logic                    q_vld;
    logic                    q_full;
    logic [QLVL_W-1:0]       q_level;
    logic [MASK_W-1:0]       f_state;
    logic [MASK_W-1:0]       f_anti1;
    logic [MASK_W-1:0]       f_anti2;
    t_acc                    f_diag;
    logic [DATA_W-1:0]       q_head;
    logic [STATE_W:0]        chk_mask;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // word-aligned decode, one register per word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coupling <= COUPLING_RST;
            r_half     <= HALF_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_COUPLING: r_coupling <= pwdata[CFG_W-1:0];
                REG_HALF:     r_half     <= pwdata[HALF_W-1:0];
                default:      r_half     <= r_half;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_COUPLING: prdata = {{(APB_DW-CFG_W){1'b0}}, r_coupling};
            REG_HALF:     prdata = {{(APB_DW-HALF_W){1'b0}}, r_half};
            default:      prdata = '0;
        endcase
    end

    // half ring length clamped to 3..8, ring then capped to the build limit
    always_comb begin
        if (r_half < HALF_W'(HALF_MIN)) begin
            half_cl = HALF_W'(HALF_MIN);
        end else if (r_half > HALF_W'(HALF_MAX)) begin
            half_cl = HALF_W'(HALF_MAX);
        end else begin
            half_cl = r_half;
        end
        len_raw = {half_cl, 1'b0};
        cfg.coupling = r_coupling;
        cfg.ring_len = (len_raw > LEN_W'(RING_MAX)) ? LEN_W'(RING_MAX) : len_raw;
    end

    // front: masks the state, classifies bonds, sums the diagonal
    schrg_front #(
        .MASK_W        (MASK_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_basis_state (i_basis_state),
        .o_push        (q_push),
        .i_full        (q_full),
        .o_state       (f_state),
        .o_anti1       (f_anti1),
        .o_anti2       (f_anti2),
        .o_diag        (f_diag)
    );

    assign q_full = (q_level == QLVL_W'(QDEPTH));

    // queue decouples intake stalls from emitter stalls
    schrg_fifo #(
        .DATA_W  (DATA_W),
        .DEPTH   (QDEPTH),
        .LVL_W   (QLVL_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_state, f_anti1, f_anti2, f_diag}),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_data  (q_head),
        .o_level (q_level)
    );

    // back: walks the pending bond mask, one entry per clock while the output is ready
    schrg_back #(
        .MASK_W         (MASK_W),
        .FRAC_BITS      (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_vld          (q_vld),
        .i_state        (q_head[DATA_W-1 -: MASK_W]),
        .i_anti1        (q_head[DATA_W-MASK_W-1 -: MASK_W]),
        .i_anti2        (q_head[T_W+MASK_W-1 -: MASK_W]),
        .i_diag         (q_head[T_W-1:0]),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_column_state (o_column_state),
        .o_entry_value  (o_entry_value),
        .o_is_diagonal  (o_is_diagonal),
        .o_last_of_row  (o_last_of_row)
    );

    // ring mask at port width, for checking columns
    assign chk_mask = ((STATE_W+1)'(1) << cfg.ring_len) - (STATE_W+1)'(1);

    // emitter only takes a row the queue really holds
    `SCHRG_ASSERT_IMP(a_pop_has_head, q_pop, q_vld)
    // queue fill tracks a lone write
    `SCHRG_ASSERT_NXT(a_level_up, q_push && !q_pop, q_level == $past(q_level) + 1'b1)
    // every column stays inside the ring
    `SCHRG_ASSERT_IMP(a_col_in_ring, o_valid, (o_column_state & ~chk_mask[STATE_W-1:0]) == '0)

endmodule

>>> bench/spin_chain_hamiltonian_row_generator_top_tb.sv
// ----------------------------------------------------------------------------
// spin_chain_hamiltonian_row_generator_top_tb
// self-checking bench for the j1-j2 ring row generator: a directed table of
// basis states, then phases of random states under changing coupling and ring
// length, with random stalls on both channels outside steady phases; every
// entry is checked against a predicted hamiltonian row
// ----------------------------------------------------------------------------
module spin_chain_hamiltonian_row_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import schrg_pkg::*;

    localparam int     MAX_SITES   = 16;
    localparam int     FRAC_BITS   = 12;
    localparam int     SETTLE      = 16;          // idle wait after the last entry due
    localparam int     CYCLE_LIMIT = 5_000_000;   // clock limit of the run guard
    localparam int     PHASE_ITEMS = 60;
    localparam int     NUM_PHASES  = 8;
    localparam int     PRINT_CAP   = 50;
    localparam logic [APB_AW-1:0] ADDR_COUPLING = {REG_COUPLING, 2'b00};
    localparam logic [APB_AW-1:0] ADDR_HALF     = {REG_HALF, 2'b00};

    // one matrix entry as it leaves the block
    typedef struct {
        logic [STATE_W-1:0] column;
        t_val               value;
        logic               diag;
        logic               last;
    } t_row_entry;

    // one row of the directed table
    typedef struct {
        logic [STATE_W-1:0] state;
        bit                 typed;   // diagonal-only row with a hand-worked value
        t_val               typed_val;
    } t_state_row;

    // one configuration phase
    typedef struct {
        logic [CFG_W-1:0]  coupling;
        logic [HALF_W-1:0] half;
        bit                steady;   // no idling on either side
    } t_phase_cfg;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_valid       = 1'b0;
    logic                  o_ready;
    logic [STATE_W-1:0]    i_basis_state = '0;
    logic                  o_valid;
    logic                  i_ready       = 1'b0;
    logic [STATE_W-1:0]    o_column_state;
    logic signed [VAL_W-1:0] o_entry_value;
    logic                  o_is_diagonal;
    logic                  o_last_of_row;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_AW-1:0]     paddr         = '0;
    logic [APB_DW-1:0]     pwdata        = '0;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    // bench copy of the configuration registers
    logic signed [CFG_W-1:0] model_coupling;
    logic [HALF_W-1:0]       model_half;

    t_row_entry row_entries_due[$];
    int         mismatches  = 0;
    int         cycle_count = 0;
    int         ready_hold  = 0;
    bit         steady      = 1'b0;

    spin_chain_hamiltonian_row_generator_top #(
        .MAX_SITES(MAX_SITES),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_basis_state  (i_basis_state),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_column_state (o_column_state),
        .o_entry_value  (o_entry_value),
        .o_is_diagonal  (o_is_diagonal),
        .o_last_of_row  (o_last_of_row),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // convert t with src fraction bits to FRAC_BITS, round half up, saturate
    function automatic t_val round_to_frac(input longint t, input int src);
        longint v;
        if (FRAC_BITS >= src) begin
            v = t <<< (FRAC_BITS - src);
        end else begin
            v = (t + (longint'(1) <<< (src - FRAC_BITS - 1))) >>> (src - FRAC_BITS);
        end
        if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
        if (v < longint'(VAL_MIN)) v = longint'(VAL_MIN);
        return t_val'(v);
    endfunction

    // queue the full hamiltonian row of one accepted basis state
    function automatic void compute_row(input logic [STATE_W-1:0] raw);
        int                 h;
        int                 n;
        int                 k;
        int                 d1;
        int                 d2;
        longint             jr;
        logic [STATE_W-1:0] mask;
        logic [STATE_W-1:0] s;
        t_row_entry         offs[$];
        t_row_entry         e;
        h = int'(model_half);
        if (h < HALF_MIN) h = HALF_MIN;
        if (h > HALF_MAX) h = HALF_MAX;
        n = 2 * h;
        if (n > MAX_SITES) n = MAX_SITES & ~1;
        mask = '0;
        for (int i = 0; i < n; i++) mask[i] = 1'b1;
        s  = raw & mask;
        jr = longint'(model_coupling);
        d1 = 0;
        d2 = 0;
        // nearest bonds first, then next-nearest, each in site order
        for (int hop = 1; hop <= 2; hop++) begin
            for (int i = 0; i < n; i++) begin
                k = (i + hop) % n;
                if (s[i] == s[k]) begin
                    if (hop == 1) d1++; else d2++;
                end else begin
                    if (hop == 1) d1--; else d2--;
                    e.column    = s;
                    e.column[i] = ~s[i];
                    e.column[k] = ~s[k];
                    // 0.5 or 0.5*J, in 13 fraction bits
                    e.value = (hop == 1) ? round_to_frac(longint'(1) <<< (OFF_FRAC - 1), OFF_FRAC)
                                         : round_to_frac(jr, OFF_FRAC);
                    e.diag  = 1'b0;
                    e.last  = 1'b0;
                    offs.insert(offs.size(), e);
                end
            end
        end
        // diagonal in 14 fraction bits: 0.25*d1 + 0.25*J*d2
        e.column = s;
        e.value  = round_to_frac(longint'(d1) * (longint'(1) <<< QUARTER_SH) + jr * d2,
                                 DIAG_FRAC);
        e.diag   = 1'b1;
        e.last   = (offs.size() == 0);
        row_entries_due.insert(row_entries_due.size(), e);
        foreach (offs[m]) begin
            offs[m].last = (m == offs.size() - 1);
            row_entries_due.insert(row_entries_due.size(), offs[m]);
        end
    endfunction

    // random basis state: mostly plain random, plus near-ferromagnetic and near-neel
    function automatic logic [STATE_W-1:0] pick_state();
        int                 r;
        logic [STATE_W-1:0] s;
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                s = $urandom_range(0, 1) ? '1 : '0;
            end
            1, 2: begin
                s = $urandom_range(0, 1) ? '1 : '0;
                s[$urandom_range(0, STATE_W-1)] ^= 1'b1;
                if ($urandom_range(0, 1)) s[$urandom_range(0, STATE_W-1)] ^= 1'b1;
            end
            3: begin
                s = $urandom_range(0, 1) ? 16'h5555 : 16'haaaa;
                s[$urandom_range(0, STATE_W-1)] ^= 1'b1;
            end
            default: begin
                s = STATE_W'($urandom());
            end
        endcase
        return s;
    endfunction

    // present one request, with an optional idle gap before it, and wait for it
    task automatic send_state(input logic [STATE_W-1:0] state, input bit typed,
                              input t_val typed_val);
        int         gap;
        t_row_entry e;
        gap = steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid       = 1'b0;
            i_basis_state = STATE_W'($urandom());
            repeat (gap) @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_basis_state = state;
        do @(posedge i_clk); while (!o_ready);
        // accepted at this edge
        if (typed) begin
            e.column  = state;
            e.value   = typed_val;
            e.diag    = 1'b1;
            e.last    = 1'b1;
            row_entries_due.insert(row_entries_due.size(), e);
        end else begin
            compute_row(state);
        end
    endtask

    // stop requesting and wait until every entry due has come out
    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (row_entries_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // apb write: setup then access, written on the access edge with pready high
    task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_COUPLING) model_coupling = data[CFG_W-1:0];
        else                       model_half     = data[HALF_W-1:0];
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        pwdata  = $urandom();
    endtask

    // entry sink stalls: alternating ready runs and random gaps
    always @(negedge i_clk) begin
        if (steady) begin
            i_ready    = 1'b1;
            ready_hold = 0;
        end else if (ready_hold > 0) begin
            ready_hold--;
        end else if (i_ready) begin
            ready_hold = pick_gap();
            if (ready_hold > 0) begin
                i_ready = 1'b0;
                ready_hold--;
            end
        end else begin
            i_ready    = 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
    end

    // entry checker: each accepted entry against the oldest one due
    always @(posedge i_clk) begin : entry_check
        t_row_entry want;
        if (i_rst_n && o_valid && i_ready) begin
            if (row_entries_due.size() == 0) begin
                report_mismatch("entry with none due, column", o_column_state, -1);
            end else begin
                want = row_entries_due.pop_front();
                if (o_column_state !== want.column)
                    report_mismatch("column_state", o_column_state, want.column);
                if (o_entry_value !== want.value)
                    report_mismatch("entry_value", o_entry_value, want.value);
                if (o_is_diagonal !== want.diag)
                    report_mismatch("is_diagonal", o_is_diagonal, want.diag);
                if (o_last_of_row !== want.last)
                    report_mismatch("last_of_row", o_last_of_row, want.last);
            end
        end
    end

    // directed table under the reset configuration (J = 1.0, 16 sites);
    // ferromagnetic rows: 0.25*16 + 0.25*16 = 8.0 -> 32768
    t_state_row directed_rows[18] = '{
        '{16'h0000, 1'b1, 24'sd32768},   // all down, diagonal only
        '{16'hffff, 1'b1, 24'sd32768},   // all up, diagonal only
        '{16'h5555, 1'b0, 24'sd0},       // neel: every nearest bond flips
        '{16'haaaa, 1'b0, 24'sd0},
        '{16'h3333, 1'b0, 24'sd0},       // every next-nearest bond flips
        '{16'hcccc, 1'b0, 24'sd0},
        '{16'h0001, 1'b0, 24'sd0},       // single up spin at site 0
        '{16'h8000, 1'b0, 24'sd0},       // single up spin at the wrap site
        '{16'hfffe, 1'b0, 24'sd0},
        '{16'h7fff, 1'b0, 24'sd0},
        '{16'h8001, 1'b0, 24'sd0},       // pair straddling the wrap
        '{16'h00ff, 1'b0, 24'sd0},
        '{16'hff00, 1'b0, 24'sd0},
        '{16'h0f0f, 1'b0, 24'sd0},
        '{16'h6666, 1'b0, 24'sd0},
        '{16'h0180, 1'b0, 24'sd0},
        '{16'h1234, 1'b0, 24'sd0},
        '{16'hfedc, 1'b0, 24'sd0}
    };

    t_phase_cfg phases[NUM_PHASES];

    initial begin
        // extremes first, saturating ring lengths among them, then random settings
        phases[0] = '{16'sd4096, 4'd8, 1'b0};
        phases[1] = '{16'h8000, 4'd3, 1'b0};
        phases[2] = '{16'h7fff, 4'd8, 1'b1};
        phases[3] = '{16'h0000, 4'd0, 1'b0};
        phases[4] = '{16'hffff, 4'd15, 1'b0};
        phases[5] = '{16'h0001, 4'd5, 1'b1};
        phases[6] = '{CFG_W'($urandom()), HALF_W'($urandom_range(0, 15)), 1'b0};
        phases[7] = '{CFG_W'($urandom()), HALF_W'($urandom_range(0, 15)), 1'b0};

        model_coupling = COUPLING_RST;
        model_half     = HALF_RST;

        // synchronous reset, released on a falling edge
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r])
            send_state(directed_rows[r].state, directed_rows[r].typed,
                       directed_rows[r].typed_val);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers only change with nothing in flight
            drain();
            steady = 1'b0;
            write_reg(ADDR_COUPLING, {APB_DW'($urandom()) >> CFG_W << CFG_W} |
                                     APB_DW'(phases[p].coupling));
            write_reg(ADDR_HALF, {APB_DW'($urandom()) >> HALF_W << HALF_W} |
                                 APB_DW'(phases[p].half));
            steady = phases[p].steady;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_state(pick_state(), 1'b0, 24'sd0);
        end

        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/schrg_pkg.sv
sv/schrg_front.sv
sv/schrg_fifo.sv
sv/schrg_back.sv
sv/spin_chain_hamiltonian_row_generator_top.sv
bench/spin_chain_hamiltonian_row_generator_top_tb.sv
